/* hw/rtl/iol_pkg.sv */
`default_nettype none

package iol_pkg;

   // Fixed field widths of the transaction payloads.
   localparam int ACTION_W   = 4;
   localparam int VALUE_W    = 32;
   localparam int POS_W      = 7;
   localparam int STATUS_W   = 2;
   localparam int LEN_W      = 7;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 40;
   localparam int RSP_USER_W = 3;

   // Default list capacity; the width of the length field allows up to 127.
   localparam int DEFAULT_CAPACITY = 32;

   typedef enum logic [ACTION_W-1:0] {
      ACT_ADD_FRONT    = 4'd0,
      ACT_ADD_BACK     = 4'd1,
      ACT_ADD_AT       = 4'd2,
      ACT_REMOVE_FRONT = 4'd3,
      ACT_REMOVE_BACK  = 4'd4,
      ACT_REMOVE_AT    = 4'd5,
      ACT_SHOW_FWD     = 4'd6,
      ACT_SHOW_REV     = 4'd7,
      ACT_CLEAR        = 4'd8
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_DONE  = 2'd0,
      STAT_INDEX = 2'd1,
      STAT_FULL  = 2'd2,
      STAT_EMPTY = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CTL_IDLE,
      CTL_RESP,
      CTL_SHOW,
      CTL_SKIP
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic exec;
      logic rot_left;
      logic rot_right;
      logic show;
      logic show_back;
      logic show_last;
   } dp_cmd_type;

endpackage

`default_nettype wire

/* hw/rtl/indexed_ordered_list_core.sv */
// Ordered list of up to CAPACITY signed 32-bit values, held in a chain of cells.
// Request channel (req_): tuser carries the action, tdata the value to insert
// and the position for the positional actions. Response channel (rsp_): tuser
// carries status and has_element, tdata the element and the list length after
// the action, tlast marks the final response of a request.
// Every request except a read-out of a non-empty list gives one response.
// Inserts and removes shift all cells at once: the response is valid the
// cycle after the request transaction, and the next request is taken in the
// same cycle as that response, so such requests run at one per cycle unless
// rsp_tready is low. A read-out of a non-empty list rotates the cell chain
// one cell per cycle unless stalled and always takes CAPACITY rotations in
// total, which leaves the list where it was. Elements are shown one per cycle
// unless stalled; the next request is taken once the read-out is done.
// When rsp_tready is low, the response holds and no new request is taken.
// Reset empties the list; the cell contents are not cleared.
`default_nettype none

module indexed_ordered_list_core
   import iol_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // value[31:0], position[38:32], zero
   input  wire logic [ACTION_W-1:0]   req_tuser,   // action[3:0]
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata,   // element[31:0], length[38:32], zero
   output logic [RSP_USER_W-1:0]      rsp_tuser,   // status[1:0], has_element[2]
   output logic                       rsp_tlast
);

   dp_cmd_type          cmd;
   logic [LEN_W-1:0]    occupancy;
   logic [STATUS_W-1:0] status;
   logic [VALUE_W-1:0]  element;
   logic                has_element;

   iol_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .action     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .occupancy  (occupancy),
      .cmd        (cmd)
   );

   iol_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .action          (req_tuser),
      .value           (req_tdata[VALUE_W-1:0]),
      .position        (req_tdata[VALUE_W +: POS_W]),
      .occupancy       (occupancy),
      .out_status      (status),
      .out_element     (element),
      .out_has_element (has_element),
      .out_last        (rsp_tlast)
   );

   // Pack the response fields.
   assign rsp_tdata = {{(RSP_DATA_W - VALUE_W - LEN_W){1'b0}}, occupancy, element};
   assign rsp_tuser = {has_element, status};

endmodule

`default_nettype wire

/* hw/rtl/iol_datapath.sv */
`default_nettype none

module iol_datapath
   import iol_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire dp_cmd_type          cmd,
   input  wire logic [ACTION_W-1:0] action,
   input  wire logic [VALUE_W-1:0]  value,
   input  wire logic [POS_W-1:0]    position,
   output logic [LEN_W-1:0]         occupancy,
   output logic [STATUS_W-1:0]      out_status,
   output logic [VALUE_W-1:0]       out_element,
   output logic                     out_has_element,
   output logic                     out_last
);

   localparam logic [LEN_W-1:0] CAP = LEN_W'(CAPACITY);

   logic [VALUE_W-1:0]  cell_ff [CAPACITY];
   logic [VALUE_W-1:0]  cell_in [CAPACITY];
   logic [LEN_W-1:0]    occ_ff;
   logic [LEN_W-1:0]    occ_in;
   status_type          status_ff;
   status_type          status_in;

   logic                ins_en;
   logic                rem_en;
   logic [POS_W-1:0]    ins_pos;
   logic [POS_W-1:0]    rem_pos;

   // Decode the action, check the position, fullness and emptiness, and pick the shift.
   always_comb begin
      ins_en    = 1'b0;
      rem_en    = 1'b0;
      ins_pos   = position;
      rem_pos   = position;
      status_in = status_ff;
      occ_in    = occ_ff;
      if (cmd.exec) begin
         status_in = STAT_DONE;
         case (action_type'(action))
            ACT_ADD_FRONT, ACT_ADD_BACK, ACT_ADD_AT: begin
               if (action_type'(action) == ACT_ADD_FRONT) begin
                  ins_pos = '0;
               end else if (action_type'(action) == ACT_ADD_BACK) begin
                  ins_pos = occ_ff;
               end
               if (ins_pos > occ_ff) begin
                  status_in = STAT_INDEX;
               end else if (occ_ff == CAP) begin
                  status_in = STAT_FULL;
               end else begin
                  ins_en = 1'b1;
                  occ_in = occ_ff + LEN_W'(1);
               end
            end
            ACT_REMOVE_FRONT, ACT_REMOVE_BACK, ACT_REMOVE_AT: begin
               if (action_type'(action) == ACT_REMOVE_FRONT) begin
                  rem_pos = '0;
               end else if (action_type'(action) == ACT_REMOVE_BACK) begin
                  rem_pos = occ_ff - LEN_W'(1);
               end
               if (occ_ff == '0) begin
                  status_in = STAT_EMPTY;
               end else if (rem_pos >= occ_ff) begin
                  status_in = STAT_INDEX;
               end else begin
                  rem_en = 1'b1;
                  occ_in = occ_ff - LEN_W'(1);
               end
            end
            ACT_CLEAR: begin
               occ_in = '0;
            end
            default: begin
               status_in = STAT_DONE;
            end
         endcase
      end
   end

   // Cell chain: each cell picks its own value, the inserted value or a fixed neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      always_comb begin
         cell_in[i] = cell_ff[i];
         if (cmd.rot_left) begin
            cell_in[i] = cell_ff[(i + 1) % CAPACITY];
         end else if (cmd.rot_right) begin
            cell_in[i] = cell_ff[(i + CAPACITY - 1) % CAPACITY];
         end else if (ins_en) begin
            if (LEN_W'(i) == ins_pos) begin
               cell_in[i] = value;
            end else if (LEN_W'(i) > ins_pos) begin
               cell_in[i] = cell_ff[(i + CAPACITY - 1) % CAPACITY];
            end
         end else if (rem_en) begin
            if ((LEN_W'(i) >= rem_pos) && (i < CAPACITY - 1)) begin
               cell_in[i] = cell_ff[(i + 1) % CAPACITY];
            end
         end
      end

      always_ff @(posedge clock) begin
         cell_ff[i] <= cell_in[i];
      end
   end

   // Length and status registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= '0;
      end else begin
         occ_ff <= occ_in;
      end
      status_ff <= status_in;
   end

   // Result fields: an element during a read-out, else the stored status.
   assign occupancy       = occ_ff;
   assign out_status      = cmd.show ? STAT_DONE : status_ff;
   assign out_element     = !cmd.show ? '0 :
                            (cmd.show_back ? cell_ff[CAPACITY-1] : cell_ff[0]);
   assign out_has_element = cmd.show;
   assign out_last        = cmd.show ? cmd.show_last : 1'b1;

endmodule

`default_nettype wire

/* hw/rtl/iol_ctrl.sv */
`default_nettype none

module iol_ctrl
   import iol_pkg::*;
#(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [ACTION_W-1:0] action,
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   input  wire logic [LEN_W-1:0]    occupancy,
   output dp_cmd_type               cmd
);

   localparam logic [LEN_W-1:0] CAP    = LEN_W'(CAPACITY);
   localparam logic [LEN_W-1:0] CAP_M1 = LEN_W'(CAPACITY - 1);

   ctl_state_type       state_ff;
   ctl_state_type       state_in;
   logic [LEN_W-1:0]    rot_ff;
   logic [LEN_W-1:0]    rot_in;
   logic                back_ff;
   logic                back_in;
   logic                accept;
   logic                is_show;
   logic                last_elem;

   assign is_show = (action_type'(action) == ACT_SHOW_FWD) ||
                    (action_type'(action) == ACT_SHOW_REV);
   assign accept  = req_tvalid && req_tready;

   // The final element is at rotation occupancy-1 going forward and
   // at rotation CAPACITY-1 going backward.
   assign last_elem = back_ff ? (rot_ff == CAP_M1)
                              : (rot_ff == occupancy - LEN_W'(1));

   // State register and rotation counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CTL_IDLE;
      end else begin
         state_ff <= state_in;
      end
      rot_ff  <= rot_in;
      back_ff <= back_in;
   end

   // Next state and commands.
   always_comb begin
      state_in   = state_ff;
      rot_in     = rot_ff;
      back_in    = back_ff;
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      cmd        = '0;
      case (state_ff)
         CTL_IDLE: begin
            req_tready = 1'b1;
         end
         CTL_RESP: begin
            rsp_tvalid = 1'b1;
            req_tready = rsp_tready;
            if (rsp_tready) begin
               state_in = CTL_IDLE;
            end
         end
         CTL_SHOW: begin
            rsp_tvalid     = 1'b1;
            cmd.show       = 1'b1;
            cmd.show_back  = back_ff;
            cmd.show_last  = last_elem;
            if (rsp_tready) begin
               cmd.rot_left  = !back_ff;
               cmd.rot_right = back_ff;
               rot_in        = rot_ff + LEN_W'(1);
               if (last_elem) begin
                  state_in = (!back_ff && (occupancy != CAP)) ? CTL_SKIP : CTL_IDLE;
               end
            end
         end
         CTL_SKIP: begin
            // Silent rotations to restore (forward) or align (reverse) the list.
            cmd.rot_left  = !back_ff;
            cmd.rot_right = back_ff;
            rot_in        = rot_ff + LEN_W'(1);
            if (back_ff) begin
               if (rot_in == CAP - occupancy) begin
                  state_in = CTL_SHOW;
               end
            end else if (rot_ff == CAP_M1) begin
               state_in = CTL_IDLE;
            end
         end
         default: begin
            state_in = CTL_IDLE;
         end
      endcase

      // A new transaction starts a read-out or runs at once.
      if (accept) begin
         if (is_show && (occupancy != '0)) begin
            back_in = (action_type'(action) == ACT_SHOW_REV);
            rot_in  = '0;
            if (back_in && (occupancy != CAP)) begin
               state_in = CTL_SKIP;
            end else begin
               state_in = CTL_SHOW;
            end
         end else begin
            cmd.exec = 1'b1;
            state_in = CTL_RESP;
         end
      end
   end

endmodule

`default_nettype wire
